FILE: design/fvwm_pkg.sv
// ----------------------------------------------------------------------------
// fvwm_pkg
// Shared constants, event codes and the controller-to-datapath command
// bundle for the four-voice wavetable mixer.
// ----------------------------------------------------------------------------
package fvwm_pkg;

    // Sizing
    localparam int VOICES       = 4;
    localparam int DECAY_DIVIDE = 32;
    localparam int TABLE_AW     = 8;
    localparam int TABLE_DEPTH  = 1 << TABLE_AW;

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW = $clog2(VOICES + 2);
    localparam int PW = (DECAY_DIVIDE > 1) ? $clog2(DECAY_DIVIDE) : 1;

    // Fixed constants of the voice math
    localparam logic [5:0] PHASE_FIELD_MASK = 6'h3f;
    localparam logic [7:0] OUT_OFFSET       = 8'h80;
    localparam logic [7:0] SUSTAIN_RESET    = 8'd40;
    localparam logic [7:0] FLOOR_RESET      = 8'd30;

    // Event codes
    typedef enum logic [2:0] {
        OP_SAMPLE    = 3'd0,
        OP_DECAY     = 3'd1,
        OP_PLAY      = 3'd2,
        OP_SET_DECAY = 3'd3,
        OP_STOP_ALL  = 3'd4,
        OP_TABLE_WR  = 3'd5
    } op_t;

    // Register indexes on the configuration port
    localparam logic REG_SUSTAIN = 1'b0;
    localparam logic REG_FLOOR   = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic          ev_apply;  // apply the accepted event this cycle
        logic          acc_clr;   // clear the mix accumulator
        logic          issue;     // start one voice through the mix pipe
        logic [VW-1:0] vsel;      // voice being issued
        logic          load_out;  // capture the finished mix
    } dp_cmd_t;

endpackage

FILE: design/fvwm_dp.sv
// ----------------------------------------------------------------------------
// fvwm_dp
// Datapath: voice state, decay prescaler, wave table RAM and the
// three-stage per-voice mix pipe (phase/index, table read, scale, sum).
// ----------------------------------------------------------------------------
module fvwm_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  fvwm_pkg::dp_cmd_t   cmd,
    input  logic [2:0]          op,
    input  logic [1:0]          voice,
    input  logic [15:0]         pitch_step,
    input  logic [7:0]          volume,
    input  logic [7:0]          decay_step,
    input  logic [7:0]          table_addr,
    input  logic signed [7:0]   table_data,
    input  logic [7:0]          sustain_level,
    input  logic [7:0]          timbre_floor,
    output logic [7:0]          mixed_sample
);
    import fvwm_pkg::*;

    // Voice state
    logic [15:0] phase_reg [VOICES];
    logic [15:0] phase_next [VOICES];
    logic [15:0] pitch_reg [VOICES];
    logic [15:0] pitch_next [VOICES];
    logic [7:0]  vol_reg [VOICES];
    logic [7:0]  vol_next [VOICES];
    logic [7:0]  decay_reg [VOICES];
    logic [7:0]  decay_next [VOICES];
    logic [PW-1:0] pre_reg;
    logic [PW-1:0] pre_next;

    // Mix pipe
    logic signed [7:0] ram_q_reg;
    logic [7:0]        vol_q_reg;
    logic              v1_reg;
    logic [15:0]       prod_reg;
    logic              v2_reg;
    logic [7:0]        acc_reg;
    logic [7:0]        acc_next;
    logic [7:0]        mixed_sample_reg;

    logic [7:0] wave_mem [TABLE_DEPTH];

    logic [15:0]        phase_sum;
    logic [7:0]         cur_vol;
    logic [7:0]         lift_off;
    logic [7:0]         tbl_idx;
    logic signed [16:0] prod_full;
    logic [VW-1:0]      play_idx;
    logic               play_ok;
    logic               tbl_wr;

    // Issue stage: phase advance and table index
    assign phase_sum = phase_reg[cmd.vsel] + pitch_reg[cmd.vsel];
    assign cur_vol   = vol_reg[cmd.vsel];
    assign lift_off  = (cur_vol > timbre_floor) ? (cur_vol - timbre_floor) : 8'd0;
    assign tbl_idx   = {2'b00, phase_sum[13:8] & PHASE_FIELD_MASK} + lift_off;

    // Scale stage: signed sample times unsigned volume
    assign prod_full = ram_q_reg * $signed({1'b0, vol_q_reg});

    assign play_idx = VW'(voice);
    assign play_ok  = {3'b000, voice} < 5'(VOICES);
    assign tbl_wr   = cmd.ev_apply && (op == OP_TABLE_WR)
                      && ({1'b0, table_addr} < 9'(TABLE_DEPTH));

    // Next voice state
    always_comb
    begin
        phase_next = phase_reg;
        pitch_next = pitch_reg;
        vol_next   = vol_reg;
        decay_next = decay_reg;
        pre_next   = pre_reg;
        if (cmd.issue)
        begin
            phase_next[cmd.vsel] = phase_sum;
        end
        if (cmd.ev_apply)
        begin
            case (op_t'(op))
                OP_DECAY:
                begin
                    pre_next = (pre_reg == '0) ? PW'(DECAY_DIVIDE - 1) : (pre_reg - 1'b1);
                    if (pre_next == '0)
                    begin
                        for (int i = 0; i < VOICES; i++)
                        begin
                            if ((vol_reg[i] != 8'd0)
                                && !(decay_reg[i] == 8'd1 && vol_reg[i] == sustain_level))
                            begin
                                vol_next[i] = (vol_reg[i] > decay_reg[i])
                                              ? (vol_reg[i] - decay_reg[i]) : 8'd0;
                            end
                        end
                    end
                end
                OP_PLAY:
                begin
                    if (play_ok)
                    begin
                        pitch_next[play_idx] = pitch_step;
                        vol_next[play_idx]   = volume;
                        decay_next[play_idx] = 8'd1;
                    end
                end
                OP_SET_DECAY:
                begin
                    for (int i = 0; i < VOICES; i++)
                    begin
                        if (pitch_reg[i] == pitch_step)
                        begin
                            decay_next[i] = decay_step;
                        end
                    end
                end
                OP_STOP_ALL:
                begin
                    for (int i = 0; i < VOICES; i++)
                    begin
                        pitch_next[i] = 16'd0;
                        phase_next[i] = 16'd0;
                        vol_next[i]   = 8'd0;
                        decay_next[i] = 8'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Accumulator next value
    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_clr)
        begin
            acc_next = 8'd0;
        end
        else if (v2_reg)
        begin
            acc_next = acc_reg + prod_reg[15:8];
        end
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICES; i++)
            begin
                phase_reg[i] <= 16'd0;
                pitch_reg[i] <= 16'd0;
                vol_reg[i]   <= 8'd0;
                decay_reg[i] <= 8'd0;
            end
            pre_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pitch_reg <= pitch_next;
            vol_reg   <= vol_next;
            decay_reg <= decay_next;
            pre_reg   <= pre_next;
            v1_reg    <= cmd.issue;
            v2_reg    <= v1_reg;
        end
    end

    // Wave table RAM: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (tbl_wr)
        begin
            wave_mem[table_addr[TABLE_AW-1:0]] <= table_data;
        end
        if (cmd.issue)
        begin
            ram_q_reg <= wave_mem[tbl_idx[TABLE_AW-1:0]];
        end
    end

    // Pipe payload
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            vol_q_reg <= cur_vol;
        end
        prod_reg <= prod_full[15:0];
        acc_reg  <= acc_next;
        if (cmd.load_out)
        begin
            mixed_sample_reg <= acc_reg + OUT_OFFSET;
        end
    end

    assign mixed_sample = mixed_sample_reg;

endmodule

FILE: design/fvwm_ctrl.sv
// ----------------------------------------------------------------------------
// fvwm_ctrl
// Controller: takes events, sequences the voices of a sample tick through
// the datapath and owns the output valid.
// ----------------------------------------------------------------------------
module fvwm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               evt_valid,
    output logic               evt_stall,
    input  logic [2:0]         op,
    output logic               mix_valid,
    input  logic               mix_stall,
    output fvwm_pkg::dp_cmd_t  cmd
);
    import fvwm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MIX,
        ST_DONE
    } state_t;

    state_t        st_reg;
    state_t        st_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          evt_accept;
    logic          is_sample;
    logic          out_free;

    assign evt_stall  = (st_reg != ST_IDLE);
    assign evt_accept = evt_valid && !evt_stall;
    assign is_sample  = (op == OP_SAMPLE);
    assign out_free   = !out_valid_reg || !mix_stall;

    // Next state and commands
    always_comb
    begin
        st_next        = st_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && mix_stall;
        cmd            = '0;
        cmd.vsel       = VW'(cnt_reg);
        case (st_reg)
            ST_IDLE:
            begin
                cmd.ev_apply = evt_accept;
                if (evt_accept && is_sample)
                begin
                    cmd.acc_clr = 1'b1;
                    cnt_next    = '0;
                    st_next     = ST_MIX;
                end
            end
            ST_MIX:
            begin
                cmd.issue = (cnt_reg < CW'(VOICES));
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CW'(VOICES + 1))
                begin
                    st_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    st_next        = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign mix_valid = out_valid_reg;

endmodule

FILE: design/four_voice_wavetable_mixer_core.sv
// ----------------------------------------------------------------------------
// four_voice_wavetable_mixer_core
// Four-voice phase-accumulator wavetable mixer with decay envelope and an
// APB register port for sustain level and timbre floor.
//
//   Channel  Signals                         Direction  Carries
//   event    evt_valid/evt_stall, op..data   in         one event per transfer
//   sample   mix_valid/mix_stall, mixed_...  out        one mix per sample tick
//   config   psel/penable/pwrite/paddr/...   in/out     sustain, floor registers
//
// A sample tick stalls the event channel after its transfer while each
// voice in turn goes through the shared table read and multiplier, the
// pipe drains and the output register is loaded. Other events do not
// hold the channel. A result waiting under mix_stall does not block
// non-sample events; a following sample tick waits at its end for the
// output register.
// Reset is asynchronous; no table clearing pass, entries are valid once written.
// ----------------------------------------------------------------------------
module four_voice_wavetable_mixer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               evt_valid,
    output logic               evt_stall,
    input  logic [2:0]         op,
    input  logic [1:0]         voice,
    input  logic [15:0]        pitch_step,
    input  logic [7:0]         volume,
    input  logic [7:0]         decay_step,
    input  logic [7:0]         table_addr,
    input  logic signed [7:0]  table_data,
    output logic               mix_valid,
    input  logic               mix_stall,
    output logic [7:0]         mixed_sample,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import fvwm_pkg::*;

    dp_cmd_t    cmd;
    logic [7:0] sustain_reg;
    logic [7:0] floor_reg;
    logic       cfg_wr;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sustain_reg <= SUSTAIN_RESET;
            floor_reg   <= FLOOR_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_SUSTAIN)
            begin
                sustain_reg <= pwdata[7:0];
            end
            else
            begin
                floor_reg <= pwdata[7:0];
            end
        end
    end

    assign prdata = {24'd0, (paddr[2] == REG_FLOOR) ? floor_reg : sustain_reg};

    fvwm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .op        (op),
        .mix_valid (mix_valid),
        .mix_stall (mix_stall),
        .cmd       (cmd)
    );

    fvwm_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .op            (op),
        .voice         (voice),
        .pitch_step    (pitch_step),
        .volume        (volume),
        .decay_step    (decay_step),
        .table_addr    (table_addr),
        .table_data    (table_data),
        .sustain_level (sustain_reg),
        .timbre_floor  (floor_reg),
        .mixed_sample  (mixed_sample)
    );

endmodule

FILE: design/fvwm_checker.sv
// ----------------------------------------------------------------------------
// fvwm_checker
// Port-level checks on the mixer core, attached by bind.
// ----------------------------------------------------------------------------
module fvwm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       evt_valid,
    input logic       evt_stall,
    input logic [2:0] op,
    input logic       mix_valid,
    input logic       mix_stall,
    input logic [7:0] mixed_sample
);
    import fvwm_pkg::*;

    // A sample tick keeps the event channel busy
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && !evt_stall && op == OP_SAMPLE) |=> evt_stall)
        else $error("event channel free right after a sample tick");

    // Other events do not hold the event channel
    a_event_single: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && !evt_stall && op != OP_SAMPLE) |=> !evt_stall)
        else $error("non-sample event held the event channel");

    // A new mix appears only at the end of a busy period
    a_mix_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mix_valid) |-> $past(evt_stall))
        else $error("mix result without a preceding sample tick");

    // A stalled mix holds
    a_mix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (mix_valid && mix_stall) |=> (mix_valid && $stable(mixed_sample)))
        else $error("stalled mix result changed or dropped");

endmodule

bind four_voice_wavetable_mixer_core fvwm_checker u_fvwm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .evt_valid    (evt_valid),
    .evt_stall    (evt_stall),
    .op           (op),
    .mix_valid    (mix_valid),
    .mix_stall    (mix_stall),
    .mixed_sample (mixed_sample)
);
